>>> rtl/core/upw_pkg.sv
// Shared types and constants of the up-peak window detector.
`timescale 1ns / 1ps

package upw_pkg;

  // Field and register widths
  localparam int unsigned CarFlagW = 8;
  localparam int unsigned WinTimeW = 16;
  localparam int unsigned ThreshW  = 15;
  localparam int unsigned DurW     = 15;
  localparam int unsigned CarCntW  = 4;
  localparam int unsigned SlotCntW = 11;
  localparam int unsigned SumW     = 15;
  localparam int unsigned TimerW   = 16;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 16;

  // Saturation limit of the per-slot departure count
  localparam logic [SlotCntW-1:0] SlotCountMax = 11'd1638;

  // Saturation limit of the reported window sum
  localparam logic [SumW-1:0] RingSumMax = 15'h7FFF;

  // Configuration register indexes
  typedef enum logic [CfgAddrW-1:0] {
    CfgWindowTime = 3'd0,
    CfgThreshold  = 3'd1,
    CfgDuration   = 3'd2,
    CfgCarCount   = 3'd3,
    CfgIdsEnable  = 3'd4,
    CfgUiEnable   = 3'd5
  } cfg_reg_e;

  // Per-lane control for one scan
  typedef struct packed {
    logic scan;      // unblocked transaction accepted
    logic clear;     // blocked transaction accepted while peak was active
    logic examined;  // lane index is below the configured car count
  } lane_ctl_t;

  // Window control for one scan
  typedef struct packed {
    logic scan;       // transaction accepted
    logic blocked;    // emergency or sabbath blocks detection
    logic clear_ring; // blocked while peak was active
    logic slot_end;   // slot timer reached the slot length
  } win_ctl_t;

endpackage

>>> rtl/core/upw_car_lane.sv
// One car lane: edge memory and rising-edge detect of a lobby departure flag.
`timescale 1ns / 1ps

module upw_car_lane (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  upw_pkg::lane_ctl_t ctl_i,
  input  logic              flag_i,
  output logic              rise_o
);
  import upw_pkg::*;

  logic mem_q, mem_d;

  // Flag a new departure of an examined car
  assign rise_o = ctl_i.examined & flag_i & ~mem_q;

  // Track the flag level, drop it when a blocked peak is torn down
  always_comb begin
    mem_d = mem_q;
    if (ctl_i.examined) begin
      if (ctl_i.clear) begin
        mem_d = 1'b0;
      end else if (ctl_i.scan) begin
        mem_d = flag_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_q <= 1'b0;
    end else begin
      mem_q <= mem_d;
    end
  end

endmodule

>>> rtl/core/upw_window.sv
// Lane merge, slot counter and moving window ring with its running total.
`timescale 1ns / 1ps

module upw_window #(
  parameter int unsigned MAX_CARS     = 8,
  parameter int unsigned WINDOW_SLOTS = 20
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  upw_pkg::win_ctl_t        ctl_i,
  input  logic [MAX_CARS-1:0]      rise_i,
  output logic [upw_pkg::SumW-1:0] total_next_o
);
  import upw_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_CARS + 1);
  localparam int unsigned PtrW = (WINDOW_SLOTS > 2) ? $clog2(WINDOW_SLOTS) : 1;
  localparam int unsigned TotW = SumW + 1;
  localparam logic [PtrW-1:0] LastSlot = PtrW'(WINDOW_SLOTS - 1);

  logic [SlotCntW-1:0] ring_q [WINDOW_SLOTS];
  logic [PtrW-1:0]     ptr_q, ptr_next;
  logic [SlotCntW-1:0] slot_q, slot_new;
  logic [SlotCntW:0]   slot_sum;
  logic [TotW-1:0]     total_q, total_calc;
  logic [CntW-1:0]     rise_cnt;

  // Merge the lanes: count rising edges of this scan
  always_comb begin
    rise_cnt = '0;
    for (int c = 0; c < MAX_CARS; c++) begin
      rise_cnt = rise_cnt + CntW'(rise_i[c]);
    end
  end

  // Add to the slot count, hold at the limit
  assign slot_sum = {1'b0, slot_q} + (SlotCntW + 1)'(rise_cnt);
  assign slot_new = (slot_sum > {1'b0, SlotCountMax}) ? SlotCountMax
                                                       : slot_sum[SlotCntW-1:0];

  // Advance the pointer with wrap
  assign ptr_next = (ptr_q >= LastSlot) ? '0 : ptr_q + PtrW'(1);

  // Replace the oldest slot in the exact total, report it saturated
  assign total_calc   = total_q - TotW'(ring_q[ptr_next]) + TotW'(slot_new);
  assign total_next_o = (total_calc > TotW'(RingSumMax)) ? RingSumMax
                                                         : total_calc[SumW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q   <= '0;
      slot_q  <= '0;
      total_q <= '0;
      for (int k = 0; k < WINDOW_SLOTS; k++) begin
        ring_q[k] <= '0;
      end
    end else if (ctl_i.scan) begin
      if (ctl_i.blocked) begin
        slot_q <= '0;
        if (ctl_i.clear_ring) begin
          total_q <= '0;
          for (int k = 0; k < WINDOW_SLOTS; k++) begin
            ring_q[k] <= '0;
          end
        end
      end else if (ctl_i.slot_end) begin
        ptr_q            <= ptr_next;
        ring_q[ptr_next] <= slot_new;
        total_q          <= total_calc;
        slot_q           <= '0;
      end else begin
        slot_q <= slot_new;
      end
    end
  end

endmodule

>>> rtl/core/up_peak_window_detector_core.sv
// Top level of the up-peak window detector: config, timers, peak control, output queue.
// A result is registered in the output register, or in the skid entry while the output is stalled.
// Throughput: one transaction per cycle while in_stall_o is low; the whole scan updates on acceptance.
// A two-entry output queue keeps accepting while one result waits; input stalls only
// when both entries are full.
// Reset (rst_ni low, asynchronous): all state but the output and skid data registers, window ring and
// config clear, car_count returns to one; no reset clearing pass is needed.
`timescale 1ns / 1ps

module up_peak_window_detector_core #(
  parameter int unsigned MAX_CARS     = 8,
  parameter int unsigned WINDOW_SLOTS = 20
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration write port
  input  logic                         cfg_we_i,
  input  logic [upw_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [upw_pkg::CfgDataW-1:0] cfg_data_i,
  // input channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [upw_pkg::CarFlagW-1:0] car_flags_i,
  input  logic                         emergency_dispatch_i,
  input  logic                         sabbath_mode_i,
  input  logic                         service_request_i,
  input  logic                         ids_request_i,
  input  logic                         ui_request_i,
  input  logic                         tick_i,
  // output channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         up_peak_active_o,
  output logic [upw_pkg::SumW-1:0]     window_sum_o
);
  import upw_pkg::*;

  // Reciprocal of the slot count for the slot length quotient
  localparam int unsigned PtrW       = (WINDOW_SLOTS > 2) ? $clog2(WINDOW_SLOTS) : 1;
  localparam int unsigned RecipShift = WinTimeW + PtrW;
  localparam int unsigned RecipW     = WinTimeW + 2;
  localparam logic [RecipW-1:0] Recip =
    RecipW'(((64'd1 << RecipShift) + WINDOW_SLOTS - 1) / WINDOW_SLOTS);
  localparam int unsigned ProdW = WinTimeW + RecipW;

  // Configuration registers
  logic [TimerW-1:0]  slot_len_q;
  logic [ThreshW-1:0] thresh_q;
  logic [DurW-1:0]    dur_q;
  logic [CarCntW-1:0] car_count_q;
  logic               ids_en_q, ui_en_q;
  logic [ProdW-1:0]   slot_prod;
  logic [ProdW-1:0]   slot_quot;

  assign slot_prod = ProdW'(cfg_data_i[WinTimeW-1:0]) * ProdW'(Recip);
  assign slot_quot = slot_prod >> RecipShift;

  // Write configuration; window time is kept as its slot length
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_len_q  <= '0;
      thresh_q    <= '0;
      dur_q       <= '0;
      car_count_q <= CarCntW'(1);
      ids_en_q    <= 1'b0;
      ui_en_q     <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        CfgWindowTime: slot_len_q  <= slot_quot[TimerW-1:0];
        CfgThreshold:  thresh_q    <= cfg_data_i[ThreshW-1:0];
        CfgDuration:   dur_q       <= cfg_data_i[DurW-1:0];
        CfgCarCount:   car_count_q <= cfg_data_i[CarCntW-1:0];
        CfgIdsEnable:  ids_en_q    <= cfg_data_i[0];
        CfgUiEnable:   ui_en_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Handshake
  logic accept;
  logic skid_valid_q;
  assign in_stall_o = skid_valid_q;
  assign accept     = in_valid_i & ~in_stall_o;

  // Scan state
  logic [TimerW-1:0] slot_timer_q, slot_timer_d, slot_timer_adv;
  logic [TimerW-1:0] hold_timer_q, hold_timer_d, hold_timer_adv;
  logic [SumW-1:0]   ring_sum_q, ring_sum_d;
  logic              peak_q, peak_d;
  logic              blocked, slot_end, trigger;
  logic [SumW-1:0]   total_next;

  assign blocked = emergency_dispatch_i | sabbath_mode_i;

  // Advance timers on tick, hold at full scale
  assign slot_timer_adv = (tick_i && slot_timer_q != '1) ? slot_timer_q + TimerW'(1)
                                                         : slot_timer_q;
  assign hold_timer_adv = (tick_i && hold_timer_q != '1) ? hold_timer_q + TimerW'(1)
                                                         : hold_timer_q;
  assign slot_end = (slot_timer_adv >= slot_len_q);

  // Car lanes
  lane_ctl_t           lane_ctl [MAX_CARS];
  logic [MAX_CARS-1:0] rise;

  for (genvar c = 0; c < MAX_CARS; c++) begin : g_lane
    logic flag;
    if (c < CarFlagW) begin : g_flag
      assign flag = car_flags_i[c];
    end else begin : g_noflag
      assign flag = 1'b0;
    end
    assign lane_ctl[c].scan     = accept & ~blocked;
    assign lane_ctl[c].clear    = accept & blocked & peak_q;
    assign lane_ctl[c].examined = (car_count_q > CarCntW'(c));

    upw_car_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (lane_ctl[c]),
      .flag_i (flag),
      .rise_o (rise[c])
    );
  end

  // Window ring
  win_ctl_t win_ctl;
  assign win_ctl.scan       = accept;
  assign win_ctl.blocked    = blocked;
  assign win_ctl.clear_ring = peak_q;
  assign win_ctl.slot_end   = slot_end;

  upw_window #(
    .MAX_CARS     (MAX_CARS),
    .WINDOW_SLOTS (WINDOW_SLOTS)
  ) u_window (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (win_ctl),
    .rise_i       (rise),
    .total_next_o (total_next)
  );

  // Peak decision for the scan
  always_comb begin
    slot_timer_d = slot_timer_adv;
    hold_timer_d = hold_timer_adv;
    ring_sum_d   = ring_sum_q;
    peak_d       = peak_q;
    trigger      = 1'b0;
    if (blocked) begin
      slot_timer_d = '0;
      ring_sum_d   = '0;
      hold_timer_d = TimerW'(dur_q) + TimerW'(1);
      peak_d       = 1'b0;
    end else begin
      if (slot_end) begin
        slot_timer_d = '0;
        ring_sum_d   = total_next;
      end
      if (dur_q == '0) begin
        peak_d       = 1'b0;
        hold_timer_d = '0;
      end else begin
        trigger = (ring_sum_d >= thresh_q) | service_request_i |
                  (ids_en_q & ids_request_i) | (ui_en_q & ui_request_i);
        if (trigger) begin
          hold_timer_d = '0;
          peak_d       = 1'b1;
        end
        if (peak_d && hold_timer_d >= TimerW'(dur_q)) begin
          peak_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_timer_q <= '0;
      hold_timer_q <= '0;
      ring_sum_q   <= '0;
      peak_q       <= 1'b0;
    end else if (accept) begin
      slot_timer_q <= slot_timer_d;
      hold_timer_q <= hold_timer_d;
      ring_sum_q   <= ring_sum_d;
      peak_q       <= peak_d;
    end
  end

  // Output register plus skid entry
  logic            out_valid_q, out_peak_q, skid_peak_q, out_take;
  logic [SumW-1:0] out_sum_q, skid_sum_q;

  assign out_take = out_valid_q & ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_take) begin
      out_valid_q  <= skid_valid_q | accept;
      skid_valid_q <= 1'b0;
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_take) begin
      if (skid_valid_q) begin
        out_peak_q <= skid_peak_q;
        out_sum_q  <= skid_sum_q;
      end else begin
        out_peak_q <= peak_d;
        out_sum_q  <= ring_sum_d;
      end
    end else if (accept) begin
      skid_peak_q <= peak_d;
      skid_sum_q  <= ring_sum_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign up_peak_active_o = out_peak_q;
  assign window_sum_o     = out_sum_q;

  // Checks
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held without an output entry");

  a_skid_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && out_stall_i))
    else $error("skid entry filled while output was free");

  a_block_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && blocked) |=> (!peak_q && ring_sum_q == '0))
    else $error("blocked scan left peak or window sum set");

endmodule

>>> dv/testbench.sv
// Self-checking testbench of the up-peak window detector core.
`timescale 1ns / 1ps

module testbench;
  import upw_pkg::*;

  localparam int unsigned MaxCars     = 8;
  localparam int unsigned WindowSlots = 20;
  localparam int unsigned SumMax      = 32767;
  localparam logic [TimerW-1:0] TimerMax = '1;
  localparam int unsigned QuietLimit  = 2000;
  localparam int unsigned PhaseScans  = 50;

  typedef struct packed {
    logic [CarFlagW-1:0] flags;
    logic                emergency;
    logic                sabbath;
    logic                service;
    logic                ids;
    logic                ui;
    logic                tick;
  } scan_t;

  typedef struct packed {
    logic            up_peak;
    logic [SumW-1:0] window_sum;
  } status_t;

  typedef struct packed {
    logic [WinTimeW-1:0] window_time;
    logic [ThreshW-1:0]  threshold;
    logic [DurW-1:0]     duration;
    logic [CarCntW-1:0]  cars;
    logic                ids_en;
    logic                ui_en;
  } setting_t;

  // DUT connections
  logic                clk_i;
  logic                rst_ni     = 1'b0;
  logic                cfg_we_i   = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic                up_peak_active_o;
  logic [SumW-1:0]     window_sum_o;
  scan_t               drive_scan = '0;

  // Detector model state
  setting_t               active_cfg = '{16'd0, 15'd0, 15'd0, 4'd1, 1'b0, 1'b0};
  bit                     car_seen [MaxCars];
  bit [SlotCntW-1:0]      departures;
  bit [SlotCntW-1:0]      ring_slot [WindowSlots];
  bit [4:0]               ring_pos;
  bit [SumW-1:0]          sum_now;
  bit [TimerW-1:0]        slot_ticks;
  bit [TimerW-1:0]        hold_ticks;
  bit                     peak_on;
  status_t                expected_status_q [$];

  // Run bookkeeping
  bit idling_on = 1'b1;
  int errors;
  int quiet_cycles;
  int scans_taken;
  int results_seen;
  int peaks_seen;
  int blocked_scans;
  int settings_written;

  up_peak_window_detector_core #(
    .MAX_CARS     (MaxCars),
    .WINDOW_SLOTS (WindowSlots)
  ) dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_addr_i           (cfg_addr_i),
    .cfg_data_i           (cfg_data_i),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .car_flags_i          (drive_scan.flags),
    .emergency_dispatch_i (drive_scan.emergency),
    .sabbath_mode_i       (drive_scan.sabbath),
    .service_request_i    (drive_scan.service),
    .ids_request_i        (drive_scan.ids),
    .ui_request_i         (drive_scan.ui),
    .tick_i               (drive_scan.tick),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .up_peak_active_o     (up_peak_active_o),
    .window_sum_o         (window_sum_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Stall the result side at random while idling is on
  always @(posedge clk_i) begin
    out_stall_i <= idling_on && ($urandom_range(99) < 29);
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Track a register write in the model copy of the configuration
  function automatic void apply_setting(input cfg_reg_e idx, input logic [CfgDataW-1:0] data);
    case (idx)
      CfgWindowTime: active_cfg.window_time = data;
      CfgThreshold:  active_cfg.threshold   = data[ThreshW-1:0];
      CfgDuration:   active_cfg.duration    = data[DurW-1:0];
      CfgCarCount:   active_cfg.cars        = data[CarCntW-1:0];
      CfgIdsEnable:  active_cfg.ids_en      = data[0];
      CfgUiEnable:   active_cfg.ui_en       = data[0];
      default: ;
    endcase
  endfunction

  // Advance the detector by one scan and queue the status it must report
  function automatic void advance_detector(input scan_t s);
    int unsigned n;
    int unsigned total;
    int          c;
    bit          blocked;
    status_t     r;
    blocked = s.emergency || s.sabbath;
    n = (active_cfg.cars > MaxCars) ? MaxCars : active_cfg.cars;
    if (s.tick) begin
      if (slot_ticks != TimerMax) slot_ticks++;
      if (hold_ticks != TimerMax) hold_ticks++;
    end
    if (!blocked) begin
      // count rising edges of the examined cars
      for (c = 0; c < n; c++) begin
        if (s.flags[c]) begin
          if (!car_seen[c]) begin
            car_seen[c] = 1'b1;
            if (departures < SlotCountMax) departures++;
          end
        end else begin
          car_seen[c] = 1'b0;
        end
      end
      // close the slot: advance, store, re-sum
      if (slot_ticks >= active_cfg.window_time / WindowSlots) begin
        ring_pos = (ring_pos < WindowSlots - 1) ? ring_pos + 5'd1 : 5'd0;
        ring_slot[ring_pos] = departures;
        departures = '0;
        total = 0;
        for (c = 0; c < WindowSlots; c++) total += ring_slot[c];
        sum_now = SumW'((total > SumMax) ? SumMax : total);
        slot_ticks = '0;
      end
      if (active_cfg.duration == 0) begin
        peak_on = 1'b0;
        hold_ticks = '0;
      end else begin
        if (sum_now >= active_cfg.threshold || s.service ||
            (active_cfg.ids_en && s.ids) || (active_cfg.ui_en && s.ui)) begin
          hold_ticks = '0;
          peak_on = 1'b1;
        end
        if (peak_on && hold_ticks >= active_cfg.duration) peak_on = 1'b0;
      end
    end else begin
      // blocked: drop the counting, wipe history only if peak was on
      blocked_scans++;
      if (peak_on) begin
        for (c = 0; c < n; c++) car_seen[c] = 1'b0;
        for (c = 0; c < WindowSlots; c++) ring_slot[c] = '0;
      end
      departures = '0;
      sum_now = '0;
      slot_ticks = '0;
      hold_ticks = TimerW'(active_cfg.duration) + TimerW'(1);
      peak_on = 1'b0;
    end
    r.up_peak = peak_on;
    r.window_sum = sum_now;
    expected_status_q.push_back(r);
  endfunction

  // Predict on accepted scans, check each accepted result against the oldest prediction
  always @(posedge clk_i) begin : scoreboard
    status_t want;
    if (rst_ni) begin
      quiet_cycles++;
      if (cfg_we_i) begin
        apply_setting(cfg_reg_e'(cfg_addr_i), cfg_data_i);
        quiet_cycles = 0;
      end
      if (in_valid_i && !in_stall_o) begin
        advance_detector(drive_scan);
        scans_taken++;
        quiet_cycles = 0;
      end
      if (out_valid_o && !out_stall_i) begin
        quiet_cycles = 0;
        results_seen++;
        if (up_peak_active_o) peaks_seen++;
        if (expected_status_q.size() == 0) begin
          report_mismatch("result with none pending, window_sum", window_sum_o, 0);
        end else begin
          want = expected_status_q.pop_front();
          if (up_peak_active_o !== want.up_peak)
            report_mismatch("up_peak_active", up_peak_active_o, want.up_peak);
          if (window_sum_o !== want.window_sum)
            report_mismatch("window_sum", window_sum_o, want.window_sum);
        end
      end
    end
  end

  initial begin : watchdog
    wait (quiet_cycles >= QuietLimit);
    $display("Timeout: no transaction for %0d cycles", QuietLimit);
    $display("Regression FAIL");
    $finish;
  end

  // Hold one scan on the input until it is taken
  task automatic send_scan(input scan_t s);
    if (idling_on && $urandom_range(99) < 29) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    drive_scan <= s;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Drop valid and drain every pending result
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_status_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  // Write every register once, only while the block is idle
  task automatic set_config(input setting_t c);
    wait_idle();
    write_reg(CfgWindowTime, c.window_time);
    write_reg(CfgThreshold,  CfgDataW'(c.threshold));
    write_reg(CfgDuration,   CfgDataW'(c.duration));
    write_reg(CfgCarCount,   CfgDataW'(c.cars));
    write_reg(CfgIdsEnable,  CfgDataW'(c.ids_en));
    write_reg(CfgUiEnable,   CfgDataW'(c.ui_en));
    cfg_we_i <= 1'b0;
    settings_written++;
  endtask

  function automatic scan_t scan_item(input logic [CarFlagW-1:0] f, input logic em,
                                      input logic sab, input logic svc, input logic ids,
                                      input logic ui, input logic tk);
    return scan_t'({f, em, sab, svc, ids, ui, tk});
  endfunction

  function automatic scan_t random_scan();
    scan_t s;
    s.flags     = CarFlagW'($urandom_range(0, 255));
    s.emergency = ($urandom_range(99) < 3);
    s.sabbath   = ($urandom_range(99) < 3);
    s.service   = ($urandom_range(99) < 3);
    s.ids       = ($urandom_range(99) < 8);
    s.ui        = ($urandom_range(99) < 8);
    s.tick      = ($urandom_range(99) < 60);
    return s;
  endfunction

  function automatic setting_t random_setting();
    setting_t c;
    case ($urandom_range(0, 3))
      0:       c.window_time = WinTimeW'($urandom_range(0, 19));
      3:       c.window_time = WinTimeW'($urandom_range(301, 65535));
      default: c.window_time = WinTimeW'($urandom_range(20, 300));
    endcase
    case ($urandom_range(0, 3))
      0:       c.threshold = '0;
      1:       c.threshold = ThreshW'($urandom_range(1, 20));
      2:       c.threshold = ThreshW'($urandom_range(21, 200));
      default: c.threshold = ThreshW'($urandom_range(201, 32767));
    endcase
    case ($urandom_range(0, 3))
      0:       c.duration = '0;
      3:       c.duration = DurW'($urandom_range(31, 32766));
      default: c.duration = DurW'($urandom_range(1, 30));
    endcase
    c.cars   = CarCntW'(($urandom_range(99) < 75) ? $urandom_range(1, 8)
                                                  : $urandom_range(0, 15));
    c.ids_en = 1'($urandom_range(0, 1));
    c.ui_en  = 1'($urandom_range(0, 1));
    return c;
  endfunction

  // Reset configuration: zero duration keeps peak off, one car counted
  task automatic test_defaults();
    send_scan(scan_item(8'hFF, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1));
    send_scan(scan_item(8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    send_scan(scan_item(8'h01, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
    send_scan(scan_item(8'hFE, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    send_scan(scan_item(8'hFF, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1));
  endtask

  // Each request source sets peak, and the hold expires after the duration
  task automatic test_request_triggers();
    set_config('{16'd0, 15'd32767, 15'd3, 4'd8, 1'b1, 1'b1});
    send_scan(scan_item(8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
    repeat (3) send_scan(scan_item(8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
    send_scan(scan_item(8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
    send_scan(scan_item(8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1));
    repeat (3) send_scan(scan_item(8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
  endtask

  // Blocking with peak on wipes the ring and edges; with peak off it keeps them
  task automatic test_blocking();
    set_config('{16'd0, 15'd2, 15'd5, 4'd8, 1'b0, 1'b0});
    send_scan(scan_item(8'h03, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    send_scan(scan_item(8'h03, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
    send_scan(scan_item(8'h03, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    send_scan(scan_item(8'h03, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
    send_scan(scan_item(8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
    send_scan(scan_item(8'h01, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
  endtask

  // Car count of zero examines nothing; above the car limit examines all
  task automatic test_car_count_limits();
    set_config('{16'd0, 15'd0, 15'd32766, 4'd0, 1'b0, 1'b0});
    send_scan(scan_item(8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
    send_scan(scan_item(8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    set_config('{16'd0, 15'd0, 15'd32766, 4'd15, 1'b0, 1'b0});
    send_scan(scan_item(8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
    send_scan(scan_item(8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
  endtask

  // Fill one long slot past the departure limit, then close it
  task automatic test_slot_saturation();
    int k;
    set_config('{16'd65535, 15'd32767, 15'd0, 4'd8, 1'b0, 1'b0});
    for (k = 0; k < 420; k++)
      send_scan(scan_item((k % 2) ? 8'h00 : 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    set_config('{16'd0, 15'd32767, 15'd0, 4'd8, 1'b0, 1'b0});
    send_scan(scan_item(8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
  endtask

  // Random scans under a series of settings, the extremes first
  task automatic test_random_phases();
    int ph;
    int k;
    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       set_config('{16'd65535, 15'd32767, 15'd32766, 4'd8, 1'b1, 1'b1});
        1:       set_config('{16'd0, 15'd0, 15'd1, 4'd1, 1'b0, 1'b0});
        default: set_config(random_setting());
      endcase
      idling_on = (ph != 3);
      for (k = 0; k < PhaseScans; k++) send_scan(random_scan());
    end
    idling_on = 1'b1;
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_defaults();
    test_request_triggers();
    test_blocking();
    test_car_count_limits();
    test_slot_saturation();
    test_random_phases();
    wait_idle();
    repeat (4) @(posedge clk_i);
    if (expected_status_q.size() != 0)
      report_mismatch("results never delivered", 0, expected_status_q.size());
    $display("Covered %0d scans under %0d register settings; %0d results checked.",
             scans_taken, settings_written, results_seen);
    $display("Up peak reported in %0d results; %0d scans were blocked.",
             peaks_seen, blocked_scans);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
